FILE: sv/sle_pkg.sv
// shared types and constants of the sequential list engine
`default_nettype none
package sle_pkg;

  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = 9;
  localparam int DATA_W   = 32;

  typedef enum logic [2:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_POP_BACK   = 3'd1,
    OP_PUSH_FRONT = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_ERASE      = 3'd5,
    OP_FIND       = 3'd6
  } opcode_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_BADPOS    = 3'd1,
    STAT_FULL      = 3'd2,
    STAT_EMPTY     = 3'd3,
    STAT_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT_UP,
    ST_WRITE_VAL,
    ST_SHIFT_DN,
    ST_FIND
  } state_t;

  typedef struct packed {
    status_t           status;
    logic [CNT_W-1:0]  found;
    logic [CNT_W-1:0]  count;
  } result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

endpackage
`default_nettype wire

FILE: sv/sequential_list_engine.sv
// top level of the sequential list engine
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+---------------------------------
//  in      | input     | in_valid / in_ready  | opcode, position, value
//  out     | output    | out_valid / out_ready| status, found_position, count
//
// push back, pop back and every rejected request finish in the accept cycle.
// push front and insert shift entries up, then store the value; pop front and erase
// shift entries down; find scans to a match or the end, one ram read per entry.
// synchronous active-low reset empties the list; ram contents are not cleared.
// a two-entry result buffer lets a new request be taken while a result waits;
// in_ready drops only while a request walks the ram or both slots are full.
`default_nettype none
module sequential_list_engine (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [2:0]                 in_opcode,
  input  wire logic [sle_pkg::CNT_W-1:0]  in_position,
  input  wire logic signed [31:0]         in_value,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [2:0]                      out_status,
  output logic [sle_pkg::CNT_W-1:0]       out_found_position,
  output logic [sle_pkg::CNT_W-1:0]       out_count
);

  sle_pkg::ram_req_t          ram_req;
  logic [sle_pkg::DATA_W-1:0] ram_rdata;
  logic                       res_space;
  logic                       res_push;
  sle_pkg::result_t           res;
  sle_pkg::result_t           out_res;

  // command sequencer
  sle_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_opcode   (in_opcode),
    .in_position (in_position),
    .in_value    (in_value),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata),
    .res_space   (res_space),
    .res_push    (res_push),
    .res         (res)
  );

  // entry storage
  sle_ram #(
    .WIDTH (sle_pkg::DATA_W),
    .DEPTH (sle_pkg::CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // result buffer
  sle_res_buf u_res_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .res       (res),
    .space     (res_space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_status         = out_res.status;
  assign out_found_position = out_res.found;
  assign out_count          = out_res.count;

endmodule
`default_nettype wire

FILE: sv/sle_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module sle_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: sv/sle_res_buf.sv
// two-entry result buffer that drives the result channel
`default_nettype none
module sle_res_buf (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire sle_pkg::result_t  res,
  output logic                   space,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sle_pkg::result_t       out_res
);

  sle_pkg::result_t slot_r [2];
  logic             rd_ptr_r, rd_ptr_nxt;
  logic             wr_ptr_r, wr_ptr_nxt;
  logic [1:0]       fill_r, fill_nxt;
  logic             pop;

  assign out_valid = (fill_r != 2'd0);
  assign space     = (fill_r != 2'd2);
  assign out_res   = slot_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;

  // pointer and fill bookkeeping
  always_comb begin
    rd_ptr_nxt = rd_ptr_r ^ pop;
    wr_ptr_nxt = wr_ptr_r ^ push;
    fill_nxt   = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 2'd1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      rd_ptr_r <= rd_ptr_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // result storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= res;
    end
  end

endmodule
`default_nettype wire

FILE: sv/sle_ctrl.sv
// command sequencer: decodes requests and walks the entry ram
`default_nettype none
module sle_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [2:0]                   in_opcode,
  input  wire logic [sle_pkg::CNT_W-1:0]    in_position,
  input  wire logic [sle_pkg::DATA_W-1:0]   in_value,
  output sle_pkg::ram_req_t                 ram_req,
  input  wire logic [sle_pkg::DATA_W-1:0]   ram_rdata,
  input  wire logic                         res_space,
  output logic                              res_push,
  output sle_pkg::result_t                  res
);

  localparam int AW = sle_pkg::ADDR_W;
  localparam int CW = sle_pkg::CNT_W;

  sle_pkg::state_t          state_r, state_nxt;
  logic [CW-1:0]            count_r, count_nxt;
  logic [AW-1:0]            ptr_r, ptr_nxt;
  logic [AW-1:0]            idx_r, idx_nxt;
  logic [sle_pkg::DATA_W-1:0] val_r, val_nxt;

  logic          accept;
  logic          full, empty, pos_ok;
  logic [CW-1:0] pos_m1;
  logic [AW-1:0] pos_idx;
  logic [AW-1:0] last_idx;
  logic [CW-1:0] ptr_inc;

  assign in_ready = (state_r == sle_pkg::ST_IDLE) && res_space;
  assign accept   = in_valid && in_ready;

  assign full     = (count_r == CW'(sle_pkg::CAPACITY));
  assign empty    = (count_r == '0);
  assign pos_ok   = (in_position != '0) && (in_position <= count_r);
  assign pos_m1   = in_position - CW'(1);
  assign pos_idx  = pos_m1[AW-1:0];
  assign last_idx = AW'(count_r - CW'(1));
  assign ptr_inc  = {1'b0, ptr_r} + CW'(1);

  // next state, ram accesses and result
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    idx_nxt       = idx_r;
    val_nxt       = val_r;
    ram_req.we    = 1'b0;
    ram_req.waddr = AW'({1'b0, ptr_r} + CW'(1));
    ram_req.wdata = ram_rdata;
    ram_req.raddr = '0;
    res_push      = 1'b0;
    res.status    = sle_pkg::STAT_OK;
    res.found     = '0;
    res.count     = count_r;

    case (state_r)
      sle_pkg::ST_IDLE: begin
        if (accept) begin
          val_nxt = in_value;
          case (sle_pkg::opcode_t'(in_opcode))
            sle_pkg::OP_PUSH_BACK: begin
              res_push = 1'b1;
              if (full) begin
                res.status = sle_pkg::STAT_FULL;
              end else begin
                ram_req.we    = 1'b1;
                ram_req.waddr = AW'(count_r);
                ram_req.wdata = in_value;
                count_nxt     = count_r + CW'(1);
                res.count     = count_nxt;
              end
            end
            sle_pkg::OP_POP_BACK: begin
              res_push = 1'b1;
              if (empty) begin
                res.status = sle_pkg::STAT_EMPTY;
              end else begin
                count_nxt = count_r - CW'(1);
                res.count = count_nxt;
              end
            end
            sle_pkg::OP_PUSH_FRONT, sle_pkg::OP_INSERT: begin
              if (full) begin
                res_push   = 1'b1;
                res.status = sle_pkg::STAT_FULL;
              end else if (in_opcode == sle_pkg::OP_INSERT && !pos_ok) begin
                res_push   = 1'b1;
                res.status = sle_pkg::STAT_BADPOS;
              end else if (empty) begin
                // push front on an empty list: store directly
                res_push      = 1'b1;
                ram_req.we    = 1'b1;
                ram_req.waddr = '0;
                ram_req.wdata = in_value;
                count_nxt     = count_r + CW'(1);
                res.count     = count_nxt;
              end else begin
                // open a slot: move entries up from the last one
                idx_nxt       = (in_opcode == sle_pkg::OP_INSERT) ? pos_idx : '0;
                ptr_nxt       = last_idx;
                ram_req.raddr = last_idx;
                count_nxt     = count_r + CW'(1);
                state_nxt     = sle_pkg::ST_SHIFT_UP;
              end
            end
            sle_pkg::OP_POP_FRONT, sle_pkg::OP_ERASE: begin
              if (in_opcode == sle_pkg::OP_POP_FRONT && empty) begin
                res_push   = 1'b1;
                res.status = sle_pkg::STAT_EMPTY;
              end else if (in_opcode == sle_pkg::OP_ERASE && !pos_ok) begin
                res_push   = 1'b1;
                res.status = sle_pkg::STAT_BADPOS;
              end else begin
                count_nxt = count_r - CW'(1);
                idx_nxt   = (in_opcode == sle_pkg::OP_ERASE) ? pos_idx : '0;
                if ({1'b0, idx_nxt} < count_nxt) begin
                  // close the gap: move later entries down
                  ptr_nxt       = idx_nxt + AW'(1);
                  ram_req.raddr = ptr_nxt;
                  state_nxt     = sle_pkg::ST_SHIFT_DN;
                end else begin
                  res_push  = 1'b1;
                  res.count = count_nxt;
                end
              end
            end
            sle_pkg::OP_FIND: begin
              if (empty) begin
                res_push   = 1'b1;
                res.status = sle_pkg::STAT_NOT_FOUND;
              end else begin
                ptr_nxt       = '0;
                ram_req.raddr = '0;
                state_nxt     = sle_pkg::ST_FIND;
              end
            end
            default: begin
              res_push = 1'b1;
            end
          endcase
        end
      end

      // rdata holds entry ptr; it moves to ptr+1
      sle_pkg::ST_SHIFT_UP: begin
        ram_req.we = 1'b1;
        if (ptr_r > idx_r) begin
          ptr_nxt       = ptr_r - AW'(1);
          ram_req.raddr = ptr_nxt;
        end else begin
          state_nxt = sle_pkg::ST_WRITE_VAL;
        end
      end

      // store the new value in the opened slot
      sle_pkg::ST_WRITE_VAL: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r;
        ram_req.wdata = val_r;
        res_push      = 1'b1;
        state_nxt     = sle_pkg::ST_IDLE;
      end

      // rdata holds entry ptr; it moves to ptr-1
      sle_pkg::ST_SHIFT_DN: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = ptr_r - AW'(1);
        if ({1'b0, ptr_r} < count_r) begin
          ptr_nxt       = ptr_r + AW'(1);
          ram_req.raddr = ptr_nxt;
        end else begin
          res_push  = 1'b1;
          state_nxt = sle_pkg::ST_IDLE;
        end
      end

      // compare one entry per cycle against the key
      sle_pkg::ST_FIND: begin
        if (ram_rdata == val_r) begin
          res_push  = 1'b1;
          res.found = ptr_inc;
          state_nxt = sle_pkg::ST_IDLE;
        end else if (ptr_inc < count_r) begin
          ptr_nxt       = ptr_r + AW'(1);
          ram_req.raddr = ptr_nxt;
        end else begin
          res_push   = 1'b1;
          res.status = sle_pkg::STAT_NOT_FOUND;
          state_nxt  = sle_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = sle_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sle_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // walk pointers and request data
  always_ff @(posedge clk) begin
    ptr_r <= ptr_nxt;
    idx_r <= idx_nxt;
    val_r <= val_nxt;
  end

endmodule
`default_nettype wire

FILE: tb/sv/sequential_list_engine_tb.sv
// self-checking testbench for the sequential list engine
`default_nettype none
module sequential_list_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         CAPACITY    = sle_pkg::CAPACITY;
  localparam int         CNT_W       = sle_pkg::CNT_W;
  localparam logic [2:0] OP_UNUSED   = 3'd7;
  localparam int         RUN_ITEMS   = 700;
  localparam int         MAX_REPORTS = 10;

  typedef struct {
    logic [2:0]       opcode;
    logic [CNT_W-1:0] position;
    logic [31:0]      value;
  } list_req_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [2:0]               in_opcode = sle_pkg::OP_PUSH_BACK;
  logic [CNT_W-1:0]         in_position = '0;
  logic signed [31:0]       in_value = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [2:0]               out_status;
  logic [CNT_W-1:0]         out_found_position;
  logic [CNT_W-1:0]         out_count;

  // requests waiting to be driven, results waiting to come back
  list_req_t          pending_reqs[$];
  sle_pkg::result_t   awaited_results[$];
  // shadow copy of the list contents, front at index 0
  logic [31:0] list_shadow[$];

  logic [31:0] value_pool[8];
  int          gen_count;
  int          gen_total;
  bit          req_taken;
  int          in_gap, in_calm, out_stall, out_calm;
  int          mismatches;
  int          n_accepted, n_results, n_find_hits, n_full, n_empty, n_badpos, peak_count;

  sequential_list_engine DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_position        (in_position),
    .in_value           (in_value),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_found_position (out_found_position),
    .out_count          (out_count)
  );

  // clock and reset
  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
  end

  // apply one command to the shadow list and return what the block must answer
  function automatic sle_pkg::result_t apply_list_cmd(logic [2:0] op, logic [CNT_W-1:0] pos,
                                                      logic [31:0] val);
    sle_pkg::result_t res;
    int      n;
    bit      is_full;
    bit      pos_ok;
    n = list_shadow.size();
    is_full = (n >= CAPACITY);
    pos_ok = (pos >= 1) && (pos <= n);
    res.status = sle_pkg::STAT_OK;
    res.found = '0;
    case (op)
      sle_pkg::OP_PUSH_BACK: begin
        if (is_full) res.status = sle_pkg::STAT_FULL;
        else list_shadow.push_back(val);
      end
      sle_pkg::OP_POP_BACK: begin
        if (n == 0) res.status = sle_pkg::STAT_EMPTY;
        else void'(list_shadow.pop_back());
      end
      sle_pkg::OP_PUSH_FRONT: begin
        if (is_full) res.status = sle_pkg::STAT_FULL;
        else list_shadow.push_front(val);
      end
      sle_pkg::OP_POP_FRONT: begin
        if (n == 0) res.status = sle_pkg::STAT_EMPTY;
        else void'(list_shadow.pop_front());
      end
      sle_pkg::OP_INSERT: begin
        // a full list is reported ahead of a bad position
        if (is_full) res.status = sle_pkg::STAT_FULL;
        else if (!pos_ok) res.status = sle_pkg::STAT_BADPOS;
        else list_shadow.insert(pos - 1, val);
      end
      sle_pkg::OP_ERASE: begin
        if (!pos_ok) res.status = sle_pkg::STAT_BADPOS;
        else list_shadow.delete(pos - 1);
      end
      sle_pkg::OP_FIND: begin
        res.status = sle_pkg::STAT_NOT_FOUND;
        foreach (list_shadow[i]) begin
          if (res.status == sle_pkg::STAT_NOT_FOUND && list_shadow[i] == val) begin
            res.status = sle_pkg::STAT_OK;
            res.found = CNT_W'(i + 1);
          end
        end
      end
      default: ;
    endcase
    res.count = CNT_W'(list_shadow.size());
    return res;
  endfunction

  // queue one request and track the occupancy it leads to
  task automatic add_req(logic [2:0] op, int pos, logic [31:0] val);
    list_req_t req;
    req.opcode = op;
    req.position = CNT_W'(pos);
    req.value = val;
    pending_reqs.push_back(req);
    gen_total++;
    case (op)
      sle_pkg::OP_PUSH_BACK, sle_pkg::OP_PUSH_FRONT: begin
        if (gen_count < CAPACITY) gen_count++;
      end
      sle_pkg::OP_INSERT: begin
        if (gen_count < CAPACITY && pos >= 1 && pos <= gen_count) gen_count++;
      end
      sle_pkg::OP_POP_BACK, sle_pkg::OP_POP_FRONT: begin
        if (gen_count > 0) gen_count--;
      end
      sle_pkg::OP_ERASE: begin
        if (pos >= 1 && pos <= gen_count) gen_count--;
      end
      default: ;
    endcase
  endtask

  // mostly values from a small pool so that find hits often
  function automatic logic [31:0] pick_value();
    if ($urandom_range(0, 99) < 60) return value_pool[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // mostly legal positions, with the edges and outside values mixed in
  function automatic int pick_position(int cnt);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, (cnt > 0) ? cnt : 1);
    if (r < 80) return 0;
    if (r < 88) return (cnt < CAPACITY) ? cnt + 1 : CAPACITY;
    if (r < 94) return CAPACITY;
    return $urandom_range(0, CAPACITY);
  endfunction

  // idle length: mostly short, a few long, with calm stretches of none
  function automatic int pick_gap(inout int calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if (r < 4) calm = $urandom_range(10, 40);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_mismatch(string msg);
    if (mismatches < MAX_REPORTS) $display("mismatch at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // request driver, changes inputs at the falling edge
  always @(negedge clk) begin
    list_req_t req;
    if (rst_n && (!in_valid || req_taken)) begin
      req_taken = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        req = pending_reqs.pop_front();
        in_opcode <= req.opcode;
        in_position <= req.position;
        in_value <= req.value;
        in_valid <= 1'b1;
        in_gap = pick_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result consumer with random stalls
  always @(negedge clk) begin
    if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) out_stall = pick_gap(out_calm);
    end
  end

  // predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    sle_pkg::result_t want;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        want = apply_list_cmd(in_opcode, in_position, in_value);
        awaited_results.push_back(want);
        req_taken = 1'b1;
        n_accepted++;
        if (in_opcode == sle_pkg::OP_FIND && want.status == sle_pkg::STAT_OK) n_find_hits++;
        if (want.status == sle_pkg::STAT_FULL) n_full++;
        if (want.status == sle_pkg::STAT_EMPTY) n_empty++;
        if (want.status == sle_pkg::STAT_BADPOS) n_badpos++;
        if (int'(want.count) > peak_count) peak_count = int'(want.count);
      end
      if (out_valid && out_ready) begin
        n_results++;
        if (awaited_results.size() == 0) begin
          note_mismatch($sformatf("result with none pending: status %0d pos %0d count %0d",
                                  out_status, out_found_position, out_count));
        end else begin
          want = awaited_results.pop_front();
          if (out_status !== want.status || out_found_position !== want.found ||
              out_count !== want.count) begin
            note_mismatch($sformatf(
              "result %0d expected status %0d pos %0d count %0d, got %0d %0d %0d",
              n_results, want.status, want.found, want.count,
              out_status, out_found_position, out_count));
          end
        end
      end
    end
  end

  // stimulus and end of run
  initial begin
    int  phase;
    int  target;
    int  op_pick;
    bit  filled;
    value_pool[0] = 32'hFFFF_FFFF;
    value_pool[1] = 32'h0000_0000;
    value_pool[2] = 32'h0000_0001;
    value_pool[3] = 32'h7FFF_FFFF;
    value_pool[4] = 32'h8000_0000;
    for (int k = 5; k < 8; k++) value_pool[k] = $urandom;

    // directed: empty list cases, extreme values, edge positions
    add_req(sle_pkg::OP_POP_BACK, 0, 32'h0);
    add_req(sle_pkg::OP_POP_FRONT, 0, 32'h0);
    add_req(sle_pkg::OP_ERASE, 1, 32'h0);
    add_req(sle_pkg::OP_INSERT, 1, 32'h1234_5678);
    add_req(sle_pkg::OP_FIND, 0, 32'h0);
    add_req(OP_UNUSED, 0, 32'h0);
    add_req(sle_pkg::OP_PUSH_BACK, 0, 32'h7FFF_FFFF);
    add_req(sle_pkg::OP_PUSH_FRONT, 0, 32'h8000_0000);
    add_req(sle_pkg::OP_PUSH_BACK, 0, 32'hFFFF_FFFF);
    add_req(sle_pkg::OP_PUSH_BACK, 0, 32'h0);
    add_req(sle_pkg::OP_INSERT, 1, 32'h5);
    add_req(sle_pkg::OP_INSERT, 5, 32'hA5A5_5A5A);
    add_req(sle_pkg::OP_INSERT, 0, 32'h1);
    add_req(sle_pkg::OP_INSERT, 7, 32'h1);
    add_req(sle_pkg::OP_INSERT, CAPACITY, 32'h1);
    add_req(sle_pkg::OP_FIND, 0, 32'hFFFF_FFFF);
    add_req(sle_pkg::OP_FIND, 0, 32'h8000_0000);
    add_req(sle_pkg::OP_FIND, 0, 32'h0BAD_F00D);
    add_req(sle_pkg::OP_ERASE, 6, 32'h0);
    add_req(sle_pkg::OP_ERASE, 1, 32'h0);
    add_req(sle_pkg::OP_ERASE, 0, 32'h0);
    add_req(sle_pkg::OP_ERASE, CAPACITY, 32'h0);
    add_req(OP_UNUSED, 3, 32'hFFFF_FFFF);
    add_req(sle_pkg::OP_POP_BACK, 0, 32'h0);
    add_req(sle_pkg::OP_POP_FRONT, 0, 32'h0);

    // random phases: mixed traffic, growth runs and drain runs,
    // with one growth run forced all the way to a full list
    filled = 1'b0;
    target = gen_total + RUN_ITEMS;
    while (gen_total < target) begin
      phase = $urandom_range(0, 9);
      if (!filled && gen_total > 120) phase = 10;
      if (phase < 5) begin
        repeat ($urandom_range(15, 50)) begin
          op_pick = ($urandom_range(0, 99) == 0) ? OP_UNUSED : $urandom_range(0, 6);
          add_req(3'(op_pick), pick_position(gen_count), pick_value());
        end
      end else if (phase < 7 || phase == 10) begin
        int goal;
        goal = (phase == 10) ? CAPACITY : gen_count + $urandom_range(8, 40);
        if (goal > CAPACITY) goal = CAPACITY;
        while (gen_count < goal) begin
          op_pick = $urandom_range(0, 5);
          if (op_pick == 0) add_req(sle_pkg::OP_FIND, 0, pick_value());
          else if (op_pick < 3) add_req(sle_pkg::OP_PUSH_BACK, 0, pick_value());
          else if (op_pick < 4) add_req(sle_pkg::OP_PUSH_FRONT, 0, pick_value());
          else add_req(sle_pkg::OP_INSERT,
                       $urandom_range(1, (gen_count > 0) ? gen_count : 1), pick_value());
        end
        if (gen_count == CAPACITY) begin
          filled = 1'b1;
          add_req(sle_pkg::OP_PUSH_BACK, 0, pick_value());
          add_req(sle_pkg::OP_PUSH_FRONT, 0, pick_value());
          add_req(sle_pkg::OP_INSERT, pick_position(gen_count), pick_value());
          add_req(sle_pkg::OP_INSERT, 0, pick_value());
          add_req(sle_pkg::OP_FIND, 0, pick_value());
        end
      end else begin
        int goal;
        goal = (phase == 9) ? 0 : gen_count - $urandom_range(8, 40);
        if (goal < 0) goal = 0;
        while (gen_count > goal) begin
          op_pick = $urandom_range(0, 5);
          if (op_pick == 0) add_req(sle_pkg::OP_FIND, 0, pick_value());
          else if (op_pick < 2) add_req(sle_pkg::OP_POP_BACK, 0, pick_value());
          else if (op_pick < 4) add_req(sle_pkg::OP_POP_FRONT, 0, pick_value());
          else add_req(sle_pkg::OP_ERASE, $urandom_range(1, gen_count), pick_value());
        end
        if (gen_count == 0) begin
          add_req(sle_pkg::OP_POP_BACK, 0, pick_value());
          add_req(sle_pkg::OP_POP_FRONT, 0, pick_value());
          add_req(sle_pkg::OP_ERASE, pick_position(0), pick_value());
          add_req(sle_pkg::OP_INSERT, pick_position(0), pick_value());
        end
      end
    end

    // drain, then watch for stray results over one full walk of the list
    @(posedge clk);
    while (!rst_n || pending_reqs.size() > 0 || in_valid || awaited_results.size() > 0)
      @(posedge clk);
    repeat (CAPACITY + 16) @(posedge clk);

    $display("ran %0d requests, %0d results, peak occupancy %0d of %0d",
             n_accepted, n_results, peak_count, CAPACITY);
    $display("find hits %0d, full rejects %0d, empty rejects %0d, bad positions %0d, errors %0d",
             n_find_hits, n_full, n_empty, n_badpos, mismatches);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #10_000_000;
    $display("timed out with %0d requests queued and %0d results outstanding",
             pending_reqs.size(), awaited_results.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
`default_nettype wire

FILE: sequential_list_engine.f
sv/sle_pkg.sv
sv/sle_ram.sv
sv/sle_res_buf.sv
sv/sle_ctrl.sv
sv/sequential_list_engine.sv
tb/sv/sequential_list_engine_tb.sv
